// ----- sv/bmbl_pkg.sv -----
`default_nettype none

package bmbl_pkg;

    // Default memory size in bytes and the fixed number of banks.
    localparam int MEM_BYTES_DEF = 65536;
    localparam int NUM_BANKS     = 4;
    localparam int BANK_W        = $clog2(NUM_BANKS);

    // The memory is one 32-bit word per row, split into byte lanes.
    localparam int LANES  = 4;
    localparam int WORD_W = 32;

    typedef logic [1:0] op_t;
    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_LOAD  = 2'd1;
    localparam op_t OP_STORE = 2'd2;

    typedef logic [1:0] size_t;
    localparam size_t SIZE_BYTE = 2'd0;
    localparam size_t SIZE_HALF = 2'd1;
    localparam size_t SIZE_WORD = 2'd2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_BANK_ZERO_END    = 3'd0;
    localparam cfg_index_t CFG_BANK_ONE_END     = 3'd1;
    localparam cfg_index_t CFG_BANK_TWO_END     = 3'd2;
    localparam cfg_index_t CFG_STORE_BUSY_TICKS = 3'd3;
    localparam cfg_index_t CFG_LOAD_BUSY_TICKS  = 3'd4;

    localparam logic [15:0] BANK_ZERO_END_RST    = 16'd16383;
    localparam logic [15:0] BANK_ONE_END_RST     = 16'd32767;
    localparam logic [15:0] BANK_TWO_END_RST     = 16'd49151;
    localparam logic [7:0]  STORE_BUSY_TICKS_RST = 8'd4;
    localparam logic [7:0]  LOAD_BUSY_TICKS_RST  = 8'd2;

    // Command from the top level to the memory.
    typedef struct packed {
        logic              rd_en;
        logic [LANES-1:0]  byte_en;
        logic [WORD_W-1:0] wdata;
    } mem_cmd_t;

endpackage

`default_nettype wire

// ----- sv/bmbl_req_if.sv -----
`default_nettype none

interface bmbl_req_if;
    import bmbl_pkg::*;

    logic        valid;
    logic        ready;
    op_t         op;
    size_t       access_size;
    logic [31:0] byte_address;
    logic [31:0] write_value;

    modport source (output valid, output op, output access_size, output byte_address,
                    output write_value, input ready);
    modport sink (input valid, input op, input access_size, input byte_address,
                  input write_value, output ready);
endinterface

`default_nettype wire

// ----- sv/bmbl_rsp_if.sv -----
`default_nettype none

interface bmbl_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [31:0] read_value;

    modport source (output valid, output accepted, output read_value, input ready);
    modport sink (input valid, input accepted, input read_value, output ready);
endinterface

`default_nettype wire

// ----- sv/bmbl_cfg_if.sv -----
`default_nettype none

interface bmbl_cfg_if;
    import bmbl_pkg::*;

    logic                  valid;
    logic                  ready;
    cfg_index_t            index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/banked_memory_with_busy_locks.sv -----
`default_nettype none

// Channel  Direction  Payload                                        Purpose
// req      in         op, access_size, byte_address, write_value     tick, load or store
// rsp      out        accepted, read_value                           one result per access
// cfg      in         index, data                                    register writes
//
// A request is taken when req.ready is high; a load or store gives its result on rsp in the
// cycle after its request is accepted, and a tick gives none. The rate of one request per
// cycle while req.ready is high is set by the single port of the word-wide memory, which
// takes one access per cycle. After reset the memory is cleared one word row per cycle,
// MEM_BYTES/4 rows (rounded up), and req.ready stays low until that pass ends; cfg writes
// are taken throughout. While a result waits, req.ready follows rsp.ready; nothing is lost.

module banked_memory_with_busy_locks #(
    parameter int MEM_BYTES = bmbl_pkg::MEM_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmbl_req_if.sink    req,
    bmbl_rsp_if.source  rsp,
    bmbl_cfg_if.sink    cfg
);
    import bmbl_pkg::*;

    localparam int ROWS  = (MEM_BYTES + LANES - 1) / LANES;
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

    typedef logic [BANK_W-1:0] bank_t;

    // Configuration registers.
    logic [15:0] zero_end_reg;
    logic [15:0] one_end_reg;
    logic [15:0] two_end_reg;
    logic [7:0]  store_ticks_reg;
    logic [7:0]  load_ticks_reg;

    // Per-bank countdowns and locks.
    logic [NUM_BANKS-1:0][7:0] count_reg;
    logic [NUM_BANKS-1:0][7:0] count_next;
    logic [NUM_BANKS-1:0]      lock_reg;
    logic [NUM_BANKS-1:0]      lock_next;

    // Result stage.
    logic        rsp_valid_reg;
    logic        rsp_accepted_reg;
    logic        rsp_load_reg;
    size_t       rsp_size_reg;
    logic [1:0]  rsp_offset_reg;

    logic              req_fire;
    logic              is_access;
    bank_t             bank_sel;
    logic              grant;
    logic [2:0]        access_len;
    logic              fault;
    logic [LANES-1:0]  lane_be;
    logic [WORD_W-1:0] lane_wdata;
    mem_cmd_t          mem_cmd;
    logic [WORD_W-1:0] mem_rdata;
    logic              clear_done;
    logic [WORD_W-1:0] read_value_sel;

    // The configuration port never stalls; the user must write only while the block is idle (not enforced).
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_end_reg    <= BANK_ZERO_END_RST;
            one_end_reg     <= BANK_ONE_END_RST;
            two_end_reg     <= BANK_TWO_END_RST;
            store_ticks_reg <= STORE_BUSY_TICKS_RST;
            load_ticks_reg  <= LOAD_BUSY_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BANK_ZERO_END:    zero_end_reg    <= cfg.data;
                CFG_BANK_ONE_END:     one_end_reg     <= cfg.data;
                CFG_BANK_TWO_END:     two_end_reg     <= cfg.data;
                CFG_STORE_BUSY_TICKS: store_ticks_reg <= cfg.data[7:0];
                CFG_LOAD_BUSY_TICKS:  load_ticks_reg  <= cfg.data[7:0];
                default:              ;
            endcase
        end
    end

    // A new request is taken when the clear pass is over and the result slot is free
    // or is being emptied in this cycle.
    assign req.ready = clear_done && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign is_access = (req.op == OP_LOAD) || (req.op == OP_STORE);

    // Bank choice looks at the first byte only and compares in order, so end addresses
    // that are out of order simply leave a bank empty.
    always_comb
    begin
        priority if (req.byte_address <= {16'd0, zero_end_reg})
        begin
            bank_sel = bank_t'(0);
        end
        else if (req.byte_address <= {16'd0, one_end_reg})
        begin
            bank_sel = bank_t'(1);
        end
        else if (req.byte_address <= {16'd0, two_end_reg})
        begin
            bank_sel = bank_t'(2);
        end
        else
        begin
            bank_sel = bank_t'(3);
        end
    end

    assign grant = is_access && !lock_reg[bank_sel];

    // Length, alignment and range check. The unused size code is a fault.
    always_comb
    begin
        unique case (req.access_size)
            SIZE_BYTE: access_len = 3'd1;
            SIZE_HALF: access_len = 3'd2;
            SIZE_WORD: access_len = 3'd4;
            default:   access_len = 3'd0;
        endcase
    end

    always_comb
    begin
        unique case (req.access_size)
            SIZE_BYTE: fault = 1'b0;
            SIZE_HALF: fault = req.byte_address[0];
            SIZE_WORD: fault = req.byte_address[1:0] != 2'd0;
            default:   fault = 1'b1;
        endcase
        if ({1'b0, req.byte_address} + {30'd0, access_len} > MEM_LIMIT)
        begin
            fault = 1'b1;
        end
    end

    // Data is big-endian, so byte offset 0 of a row sits in the top lane.
    always_comb
    begin
        unique case (req.access_size)
            SIZE_BYTE:
            begin
                lane_be    = LANES'(1) << (2'd3 - req.byte_address[1:0]);
                lane_wdata = {4{req.write_value[7:0]}};
            end
            SIZE_HALF:
            begin
                lane_be    = req.byte_address[1] ? 4'b0011 : 4'b1100;
                lane_wdata = {2{req.write_value[15:0]}};
            end
            default:
            begin
                lane_be    = 4'b1111;
                lane_wdata = req.write_value;
            end
        endcase
    end

    always_comb
    begin
        mem_cmd.rd_en   = req_fire && (req.op == OP_LOAD) && grant && !fault;
        mem_cmd.byte_en = (req_fire && (req.op == OP_STORE) && grant && !fault)
                          ? lane_be : '0;
        mem_cmd.wdata   = lane_wdata;
    end

    bmbl_mem #(
        .ROWS (ROWS)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (mem_cmd),
        .row        (req.byte_address[ROW_W+1:2]),
        .rdata      (mem_rdata),
        .clear_done (clear_done)
    );

    // A tick counts every running countdown down and frees a bank when it reaches zero.
    // A granted access reloads its bank's countdown; only a store sets the lock.
    always_comb
    begin
        count_next = count_reg;
        lock_next  = lock_reg;
        if (req_fire && (req.op == OP_TICK))
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                if (count_reg[b] != 8'd0)
                begin
                    count_next[b] = count_reg[b] - 8'd1;
                    if (count_reg[b] == 8'd1)
                    begin
                        lock_next[b] = 1'b0;
                    end
                end
            end
        end
        else if (req_fire && grant)
        begin
            if (req.op == OP_STORE)
            begin
                count_next[bank_sel] = store_ticks_reg;
                lock_next[bank_sel]  = 1'b1;
            end
            else
            begin
                count_next[bank_sel] = load_ticks_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lock_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            lock_reg  <= lock_next;
        end
    end

    // Result slot: filled by every load or store request, emptied when rsp is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            rsp_valid_reg <= is_access;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_accepted_reg <= grant;
            rsp_load_reg     <= mem_cmd.rd_en;
            rsp_size_reg     <= req.access_size;
            rsp_offset_reg   <= req.byte_address[1:0];
        end
    end

    // Pick the loaded bytes out of the registered row; stores, refusals and faulting
    // loads read as zero.
    always_comb
    begin
        read_value_sel = '0;
        if (rsp_load_reg)
        begin
            unique case (rsp_size_reg)
                SIZE_BYTE:
                begin
                    unique case (rsp_offset_reg)
                        2'd0:    read_value_sel = {24'd0, mem_rdata[31:24]};
                        2'd1:    read_value_sel = {24'd0, mem_rdata[23:16]};
                        2'd2:    read_value_sel = {24'd0, mem_rdata[15:8]};
                        default: read_value_sel = {24'd0, mem_rdata[7:0]};
                    endcase
                end
                SIZE_HALF:
                begin
                    read_value_sel = rsp_offset_reg[1] ? {16'd0, mem_rdata[15:0]}
                                                       : {16'd0, mem_rdata[31:16]};
                end
                default:
                begin
                    read_value_sel = mem_rdata;
                end
            endcase
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.accepted   = rsp_accepted_reg;
    assign rsp.read_value = read_value_sel;

    // A refused access never returns data.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.accepted |-> rsp.read_value == '0)
        else $error("refused access returned data");

    // No request is taken before the memory has been cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !req.ready)
        else $error("request ready during clear pass");

    // A granted store leaves its bank locked.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req.op == OP_STORE) && grant |=> lock_reg[$past(bank_sel)])
        else $error("granted store did not lock its bank");

    // The memory is written only by granted stores that do not fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.byte_en != '0 |-> clear_done && grant && !fault && (req.op == OP_STORE))
        else $error("memory written outside a granted store");

endmodule

`default_nettype wire

// ----- sv/bmbl_mem.sv -----
`default_nettype none

module bmbl_mem #(
    parameter int ROWS = bmbl_pkg::MEM_BYTES_DEF / bmbl_pkg::LANES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bmbl_pkg::mem_cmd_t              cmd,
    input  wire logic [$clog2(ROWS)-1:0]         row,
    output logic [bmbl_pkg::WORD_W-1:0]          rdata,
    output logic                                 clear_done
);
    import bmbl_pkg::*;

    localparam int ROW_W = $clog2(ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [WORD_W-1:0] mem [ROWS];
    logic [WORD_W-1:0] rdata_reg;
    logic [ROW_W-1:0]  clear_row_reg;
    logic              clear_done_reg;

    // After reset the array is swept to zero one row per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_row_reg  <= '0;
            clear_done_reg <= 1'b0;
        end
        else if (!clear_done_reg)
        begin
            if (clear_row_reg == LAST_ROW)
            begin
                clear_done_reg <= 1'b1;
            end
            clear_row_reg <= clear_row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clear_done_reg)
        begin
            mem[clear_row_reg] <= '0;
        end
        else
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (cmd.byte_en[k])
                begin
                    mem[row][8*k +: 8] <= cmd.wdata[8*k +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[row];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_done = clear_done_reg;

endmodule

`default_nettype wire
